[sv/dfhb_pkg.sv]
// Shared types, codes and constants for the data frame header builder.
// Used by the front, queue, back and top-level modules; depends on nothing.
package dfhb_pkg;

  // Longest frame that the budget may ask for.
  localparam int unsigned MAX_FRAME_BYTES = 127;

  // Request queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Input item kinds carried on tuser.
  localparam logic MODE_HEADER  = 1'b0;
  localparam logic MODE_PAYLOAD = 1'b1;

  // Addressing mode codes.
  localparam logic [1:0] ADDR_NONE     = 2'd0;
  localparam logic [1:0] ADDR_PAN_ONLY = 2'd1;
  localparam logic [1:0] ADDR_SHORT    = 2'd2;
  localparam logic [1:0] ADDR_EXT      = 2'd3;

  // Field sizes in bytes.
  localparam logic [4:0] HDR_FIXED_BYTES = 5'd3;
  localparam logic [4:0] PAN_BYTES       = 5'd2;
  localparam logic [4:0] SHORT_BYTES     = 5'd2;
  localparam logic [4:0] EXT_BYTES       = 5'd8;

  // Destination address size indexed by destination mode.
  localparam logic [3:0] DST_SIZE [4] = '{4'd0, 4'd0, 4'd2, 4'd8};

  // Frame control bits.
  localparam logic [15:0] FC_TYPE_DATA = 16'h0001;
  localparam logic [15:0] FC_ACK_REQ   = 16'h0020;
  localparam logic [15:0] FC_PAN_COMP  = 16'h0040;
  localparam int unsigned FC_PAN_COMP_BIT = 6;

  // Configuration register indexes.
  localparam logic [1:0] CFG_OWN_PAN   = 2'd0;
  localparam logic [1:0] CFG_OWN_SHORT = 2'd1;
  localparam logic [1:0] CFG_OWN_EXT   = 2'd2;
  localparam logic [1:0] CFG_FC_OVR    = 2'd3;

  // Configuration register file contents.
  typedef struct packed {
    logic [15:0] own_pan_id;
    logic [15:0] own_short_address;
    logic [63:0] own_extended_address;
    logic [15:0] frame_control_override;
  } cfg_t;

  // One queued request: a whole header or one payload byte.
  typedef struct packed {
    logic        kind;      // MODE_HEADER or MODE_PAYLOAD
    logic [15:0] fc;        // frame control word
    logic [1:0]  dmode;
    logic [1:0]  smode;
    logic [15:0] dpan;
    logic [63:0] data;      // destination address, or payload byte in [7:0]
    logic [4:0]  hlen;      // header bytes
    logic        last;      // header: no payload follows; payload: final byte
    logic [6:0]  flen;      // frame length
  } entry_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Header field sequencer states of the back end.
  typedef enum logic [2:0] {
    SEG_IDLE,
    SEG_FC,
    SEG_SEQ,
    SEG_DPAN,
    SEG_DADDR,
    SEG_SPAN,
    SEG_SRC
  } seg_t;

endpackage

[sv/dfhb_queue.sv]
// Two-entry request queue between the front and back ends.
// Depends on dfhb_pkg for the entry and status types.
module dfhb_queue
  import dfhb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  entry_t    push_data,
  input  logic      pop,
  output entry_t    head,
  output q_status_t status
);

  entry_t                 slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;

  // Status and head of queue.
  assign status.full  = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign head         = slots[rd_ptr];

  // Pointer and fill count update.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

[sv/dfhb_front.sv]
// Front end: accepts input items, builds the frame control word, sizes the
// header and payload, queues a request per kept item. Depends on dfhb_pkg.
module dfhb_front
  import dfhb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      in_valid,
  input  logic      in_mode,
  input  logic [6:0]  frame_budget,
  input  logic [1:0]  dst_addr_mode,
  input  logic [15:0] dst_pan_id,
  input  logic [63:0] dst_address,
  input  logic [1:0]  src_addr_mode,
  input  logic        ack_wanted,
  input  logic [6:0]  payload_length,
  input  logic [7:0]  payload_byte,
  output logic      in_ready,
  input  q_status_t q_status,
  output logic      push,
  output entry_t    push_data
);

  logic [6:0]  payload_left;
  logic [6:0]  current_frame_length;

  logic        accept;
  logic [6:0]  budget_c;
  logic        bcast;
  logic [15:0] fc;
  logic [4:0]  hlen;
  logic [6:0]  room;
  logic [6:0]  plen_t;
  logic [6:0]  flen;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;

  // Header sizing and frame control word.
  always_comb begin
    budget_c = (32'(frame_budget) > MAX_FRAME_BYTES) ? 7'(MAX_FRAME_BYTES) : frame_budget;
    bcast    = (dst_addr_mode == ADDR_SHORT) && (dst_address[15:0] == 16'hFFFF);
    if (cfg.frame_control_override != 16'd0) begin
      fc = cfg.frame_control_override;
    end else begin
      fc = FC_TYPE_DATA;
      if (ack_wanted && !bcast) begin
        fc = fc | FC_ACK_REQ;
      end
      if ((dst_addr_mode != ADDR_NONE) && (dst_pan_id == cfg.own_pan_id)) begin
        fc = fc | FC_PAN_COMP;
      end
      fc[11:10] = dst_addr_mode;
      fc[15:14] = src_addr_mode;
    end
    hlen = HDR_FIXED_BYTES;
    if (dst_addr_mode != ADDR_NONE) begin
      hlen = hlen + PAN_BYTES + 5'(DST_SIZE[dst_addr_mode]);
    end
    if (src_addr_mode != ADDR_NONE) begin
      if (!fc[FC_PAN_COMP_BIT]) begin
        hlen = hlen + PAN_BYTES;
      end
      hlen = hlen + ((src_addr_mode == ADDR_SHORT) ? SHORT_BYTES : EXT_BYTES);
    end
    room   = (budget_c > {2'b00, hlen}) ? (budget_c - {2'b00, hlen}) : 7'd0;
    plen_t = (payload_length > room) ? room : payload_length;
    flen   = 7'({2'b00, hlen} + plen_t);
  end

  // Request to the back end.
  always_comb begin
    push_data = '0;
    push      = 1'b0;
    if (in_mode == MODE_HEADER) begin
      push            = accept;
      push_data.kind  = MODE_HEADER;
      push_data.fc    = fc;
      push_data.dmode = dst_addr_mode;
      push_data.smode = src_addr_mode;
      push_data.dpan  = dst_pan_id;
      push_data.data  = dst_address;
      push_data.hlen  = hlen;
      push_data.last  = (plen_t == 7'd0);
      push_data.flen  = flen;
    end else begin
      // A payload byte with nothing expected is dropped here.
      push                = accept && (payload_left != 7'd0);
      push_data.kind      = MODE_PAYLOAD;
      push_data.data[7:0] = payload_byte;
      push_data.last      = (payload_left == 7'd1);
      push_data.flen      = current_frame_length;
    end
  end

  // Frame state: a header restarts the count, payload bytes consume it.
  always_ff @(posedge clk) begin
    if (rst) begin
      payload_left         <= '0;
      current_frame_length <= '0;
    end else if (accept) begin
      if (in_mode == MODE_HEADER) begin
        payload_left         <= plen_t;
        current_frame_length <= flen;
      end else if (payload_left != 7'd0) begin
        payload_left <= payload_left - 1'b1;
      end
    end
  end

endmodule

[sv/dfhb_back.sv]
// Back end: takes requests from the queue and sends the frame one byte per
// cycle through an output register when unstalled. Depends on dfhb_pkg.
module dfhb_back
  import dfhb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  entry_t     head,
  input  q_status_t  q_status,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic [6:0] out_len
);

  seg_t        seg;
  seg_t        seg_next;
  logic [2:0]  idx;
  logic [2:0]  idx_next;
  logic [4:0]  rem;
  logic [4:0]  rem_next;

  logic [15:0] hdr_fc;
  logic [1:0]  hdr_dmode;
  logic [1:0]  hdr_smode;
  logic [15:0] hdr_dpan;
  logic [63:0] hdr_daddr;
  logic        hdr_last;
  logic [6:0]  hdr_flen;

  logic        advance;
  logic        emit;
  logic [63:0] field;
  logic [7:0]  byte_v;
  logic        last_v;
  logic [6:0]  len_v;
  logic [3:0]  cur_len;
  seg_t        tail_seg;

  // Bytes in a header field for the frame in progress.
  function automatic logic [3:0] seg_len(seg_t s, logic [1:0] dm, logic [1:0] sm,
                                         logic comp);
    logic [3:0] l;
    case (s)
      SEG_FC:    l = 4'(PAN_BYTES);
      SEG_SEQ:   l = 4'd1;
      SEG_DPAN:  l = (dm != ADDR_NONE) ? 4'(PAN_BYTES) : 4'd0;
      SEG_DADDR: l = DST_SIZE[dm];
      SEG_SPAN:  l = ((sm != ADDR_NONE) && !comp) ? 4'(PAN_BYTES) : 4'd0;
      SEG_SRC:   l = (sm == ADDR_NONE) ? 4'd0 :
                     ((sm == ADDR_SHORT) ? 4'(SHORT_BYTES) : 4'(EXT_BYTES));
      default:   l = 4'd0;
    endcase
    return l;
  endfunction

  assign advance  = !out_valid || out_ready;
  assign cur_len  = seg_len(seg, hdr_dmode, hdr_smode, hdr_fc[FC_PAN_COMP_BIT]);
  assign tail_seg = ((hdr_smode != ADDR_NONE) && !hdr_fc[FC_PAN_COMP_BIT]) ? SEG_SPAN
                                                                          : SEG_SRC;

  // Output selection: the byte that goes out in this step.
  always_comb begin
    pop    = 1'b0;
    emit   = 1'b0;
    byte_v = 8'd0;
    last_v = 1'b0;
    len_v  = hdr_flen;
    case (seg)
      SEG_FC:    field = {48'd0, hdr_fc};
      SEG_DPAN:  field = {48'd0, hdr_dpan};
      SEG_DADDR: field = hdr_daddr;
      SEG_SPAN:  field = {48'd0, cfg.own_pan_id};
      SEG_SRC:   field = (hdr_smode == ADDR_SHORT) ? {48'd0, cfg.own_short_address}
                                                   : cfg.own_extended_address;
      default:   field = 64'd0;
    endcase
    if (seg == SEG_IDLE) begin
      if (advance && !q_status.empty) begin
        pop   = 1'b1;
        emit  = 1'b1;
        len_v = head.flen;
        if (head.kind == MODE_PAYLOAD) begin
          byte_v = head.data[7:0];
          last_v = head.last;
        end else begin
          // First frame control byte goes out as the header is taken.
          byte_v = head.fc[7:0];
          last_v = 1'b0;
        end
      end
    end else if (advance) begin
      emit   = 1'b1;
      byte_v = field[{idx, 3'b000} +: 8];
      last_v = hdr_last && (rem == 5'd1);
    end
  end

  // Next state of the header field sequencer.
  always_comb begin
    seg_next = seg;
    idx_next = idx;
    rem_next = rem;
    if (seg == SEG_IDLE) begin
      if (pop && (head.kind == MODE_HEADER)) begin
        seg_next = SEG_FC;
        idx_next = 3'd1;
        rem_next = head.hlen - 1'b1;
      end
    end else if (advance) begin
      rem_next = rem - 1'b1;
      if (rem == 5'd1) begin
        seg_next = SEG_IDLE;
        idx_next = 3'd0;
      end else if ({1'b0, idx} == cur_len - 1'b1) begin
        idx_next = 3'd0;
        case (seg)
          SEG_FC:    seg_next = SEG_SEQ;
          SEG_SEQ:   seg_next = (hdr_dmode != ADDR_NONE) ? SEG_DPAN : tail_seg;
          SEG_DPAN:  seg_next = (DST_SIZE[hdr_dmode] != 4'd0) ? SEG_DADDR : tail_seg;
          SEG_DADDR: seg_next = tail_seg;
          SEG_SPAN:  seg_next = SEG_SRC;
          default:   seg_next = SEG_IDLE;
        endcase
      end else begin
        idx_next = idx + 1'b1;
      end
    end
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      seg <= SEG_IDLE;
      idx <= '0;
      rem <= '0;
    end else begin
      seg <= seg_next;
      idx <= idx_next;
      rem <= rem_next;
    end
  end

  // Header held while its fields go out.
  always_ff @(posedge clk) begin
    if (pop && (head.kind == MODE_HEADER)) begin
      hdr_fc    <= head.fc;
      hdr_dmode <= head.dmode;
      hdr_smode <= head.smode;
      hdr_dpan  <= head.dpan;
      hdr_daddr <= head.data;
      hdr_last  <= head.last;
      hdr_flen  <= head.flen;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte <= byte_v;
      out_last <= last_v;
      out_len  <= len_v;
    end
  end

  // The remaining count is zero exactly when no header is in progress.
  a_idle_rem: assert property (@(posedge clk) disable iff (rst)
    (seg == SEG_IDLE) == (rem == 5'd0))
    else $error("header byte count out of step with sequencer");

  // A request is only taken from a queue that holds one.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("pop from an empty queue");

  // The byte index always lies within the current field.
  a_idx_in_field: assert property (@(posedge clk) disable iff (rst)
    (seg != SEG_IDLE) |-> ({1'b0, idx} < cur_len))
    else $error("byte index beyond header field");

endmodule

[sv/data_frame_header_builder.sv]
// When the back end is idle, a request accepted on s_* is written into the queue,
// then taken into the back end's output register, which drives m_tvalid.
// A payload request gives one frame byte; a header request gives its header bytes
// (3 to 23) in turn, through the back end's byte sequencer and output register.
// A two-entry queue holds up to two requests while the back end is busy; s_tready
// drops only while it is full.
// Reset (rst, synchronous, active high) empties the queue, clears the frame
// state and loads the configuration registers with their reset values.
module data_frame_header_builder
  import dfhb_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  // Configuration write port.
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_wdata,
  // Input stream.
  input  logic         s_tvalid,
  output logic         s_tready,
  // s_tdata: frame_budget[6:0], dst_addr_mode[8:7], dst_pan_id[24:9],
  // dst_address[88:25], src_addr_mode[90:89], ack_wanted[91],
  // payload_length[98:92], payload_byte[106:99], zero[111:107]
  input  logic [111:0] s_tdata,
  input  logic         s_tuser,   // mode
  // Output stream.
  output logic         m_tvalid,
  input  logic         m_tready,
  // m_tdata: frame_byte[7:0], frame_length[14:8], zero[15]
  output logic [15:0]  m_tdata,
  output logic         m_tlast    // last_byte
);

  cfg_t      cfg;
  entry_t    push_data;
  entry_t    head;
  q_status_t q_status;
  logic      push;
  logic      pop;
  logic [7:0] out_byte;
  logic [6:0] out_len;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_pan_id             <= 16'hFFFF;
      cfg.own_short_address      <= 16'hFFFF;
      cfg.own_extended_address   <= 64'd0;
      cfg.frame_control_override <= 16'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OWN_PAN:   cfg.own_pan_id             <= cfg_wdata[15:0];
        CFG_OWN_SHORT: cfg.own_short_address      <= cfg_wdata[15:0];
        CFG_OWN_EXT:   cfg.own_extended_address   <= cfg_wdata;
        CFG_FC_OVR:    cfg.frame_control_override <= cfg_wdata[15:0];
        default:       cfg.own_pan_id             <= cfg.own_pan_id;
      endcase
    end
  end

  dfhb_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (s_tvalid),
    .in_mode        (s_tuser),
    .frame_budget   (s_tdata[6:0]),
    .dst_addr_mode  (s_tdata[8:7]),
    .dst_pan_id     (s_tdata[24:9]),
    .dst_address    (s_tdata[88:25]),
    .src_addr_mode  (s_tdata[90:89]),
    .ack_wanted     (s_tdata[91]),
    .payload_length (s_tdata[98:92]),
    .payload_byte   (s_tdata[106:99]),
    .in_ready       (s_tready),
    .q_status       (q_status),
    .push           (push),
    .push_data      (push_data)
  );

  dfhb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  dfhb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (out_byte),
    .out_last  (m_tlast),
    .out_len   (out_len)
  );

  assign m_tdata = {1'b0, out_len, out_byte};

endmodule
